>>> hdl/reku_pkg.sv
// Package for the rotary encoder / key event unit.
// Request payload types, result codes and register map constants.
// No dependencies.
package reku_pkg;

    localparam int POS_WIDTH = 32;
    localparam int CFG_ADDR_WIDTH = 3;
    localparam int CFG_DATA_WIDTH = 32;
    localparam int DEB_WIDTH = 4;

    localparam logic [DEB_WIDTH-1:0] DEBOUNCE_RESET = 4'd3;

    // Register word index (paddr[2])
    localparam logic REG_DEBOUNCE = 1'b0;

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_FETCH  = 1'b1;

    localparam logic [2:0] EV_NONE   = 3'd0;
    localparam logic [2:0] EV_CW     = 3'd1;
    localparam logic [2:0] EV_CCW    = 3'd2;
    localparam logic [2:0] EV_BUTTON = 3'd3;
    localparam logic [2:0] EV_KEY    = 3'd4;

    typedef struct packed {
        logic mode;
        logic chan_a;
        logic chan_b;
        logic key_level;
        logic button_level;
    } req_t;

    typedef struct packed {
        logic [2:0]                  event_code;
        logic signed [POS_WIDTH-1:0] position;
    } rsp_t;

    typedef struct packed {
        logic sample;   // sample request accepted
        logic pressed;  // raw input is in its pressed level
        logic clear;    // fetch consumes this pending flag
    } deb_ctrl_t;

endpackage

>>> hdl/rotary_encoder_key_event_unit_top.sv
// Rotary encoder decoder with debounced key and button; event fetch interface.
// Depends on reku_pkg and reku_debounce.
//
// One request per cycle is accepted while s_ready is high. A sample
// request (mode 0) updates the position count on a falling edge of channel
// A (B low counts up, B high counts down) and steps the key and button
// debouncers; it gives no result. A fetch request (mode 1) gives one result
// in the cycle after acceptance when the result register is free: the
// highest-priority event (rotation, button, key) and the low 32 bits of the
// position. The result register plus a one-entry skid stage let requests
// keep flowing while a result waits; s_ready drops only when both are full.
// The press threshold register (APB offset 0, 4 bits) sets the samples
// needed per press.
module rotary_encoder_key_event_unit_top #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  reku_pkg::req_t                         s_data,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output reku_pkg::rsp_t                         m_data,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [reku_pkg::CFG_ADDR_WIDTH-1:0]    paddr,
    input  logic [reku_pkg::CFG_DATA_WIDTH-1:0]    pwdata,
    output logic [reku_pkg::CFG_DATA_WIDTH-1:0]    prdata,
    output logic                                   pready
);
    import reku_pkg::*;

    logic [DEB_WIDTH-1:0]   debounce_reg;
    logic                   prev_a_reg;
    logic [COUNT_WIDTH-1:0] pos_reg, pos_next;
    logic [COUNT_WIDTH-1:0] rep_reg, rep_next;
    logic [COUNT_WIDTH-1:0] delta;
    logic                   key_pending, button_pending;
    deb_ctrl_t              key_ctrl, button_ctrl;
    logic                   accept, sample_acc, fetch_acc;
    logic [2:0]             code;
    logic [POS_WIDTH-1:0]   pos32;
    rsp_t                   rsp;
    rsp_t                   out_reg, skid_reg;
    logic                   out_valid_reg, skid_valid_reg;
    logic                   out_free;

    // Configuration port
    assign pready = 1'b1;
    assign prdata = {{(CFG_DATA_WIDTH-DEB_WIDTH){1'b0}}, debounce_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= DEBOUNCE_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == REG_DEBOUNCE) begin
            debounce_reg <= pwdata[DEB_WIDTH-1:0];
        end
    end

    // Request decode
    assign s_ready    = !skid_valid_reg;
    assign accept     = s_valid && s_ready;
    assign sample_acc = accept && s_data.mode == MODE_SAMPLE;
    assign fetch_acc  = accept && s_data.mode == MODE_FETCH;

    // Position tracking and event selection
    assign delta = pos_reg - rep_reg;

    always_comb begin
        pos_next = pos_reg;
        rep_next = rep_reg;
        code     = EV_NONE;
        if (sample_acc && prev_a_reg && !s_data.chan_a) begin
            if (!s_data.chan_b) begin
                pos_next = pos_reg + COUNT_WIDTH'(1);
            end else begin
                pos_next = pos_reg - COUNT_WIDTH'(1);
            end
        end
        if (delta != '0) begin
            code = delta[COUNT_WIDTH-1] ? EV_CCW : EV_CW;
            if (fetch_acc) begin
                rep_next = pos_reg;
            end
        end else if (button_pending) begin
            code = EV_BUTTON;
        end else if (key_pending) begin
            code = EV_KEY;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_a_reg <= 1'b1;
            pos_reg    <= '0;
            rep_reg    <= '0;
        end else begin
            if (sample_acc) begin
                prev_a_reg <= s_data.chan_a;
            end
            pos_reg <= pos_next;
            rep_reg <= rep_next;
        end
    end

    assign key_ctrl.sample    = sample_acc;
    assign key_ctrl.pressed   = s_data.key_level;
    assign key_ctrl.clear     = fetch_acc && code == EV_KEY;
    assign button_ctrl.sample  = sample_acc;
    assign button_ctrl.pressed = !s_data.button_level;
    assign button_ctrl.clear   = fetch_acc && code == EV_BUTTON;

    reku_debounce u_key_deb (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (key_ctrl),
        .limit   (debounce_reg),
        .pending (key_pending)
    );

    reku_debounce u_button_deb (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (button_ctrl),
        .limit   (debounce_reg),
        .pending (button_pending)
    );

    generate
        if (COUNT_WIDTH >= POS_WIDTH) begin : g_pos_trunc
            assign pos32 = pos_reg[POS_WIDTH-1:0];
        end else begin : g_pos_ext
            assign pos32 = {{(POS_WIDTH-COUNT_WIDTH){1'b0}}, pos_reg};
        end
    endgenerate

    assign rsp.event_code = code;
    assign rsp.position   = pos32;

    // Result register with skid stage
    assign out_free = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= fetch_acc;
            end
        end else if (fetch_acc) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            out_reg <= skid_valid_reg ? skid_reg : rsp;
        end
        if (!out_free && fetch_acc) begin
            skid_reg <= rsp;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

>>> hdl/reku_debounce.sv
// Saturating press debouncer with a pending flag.
// Depends on reku_pkg.
module reku_debounce (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  reku_pkg::deb_ctrl_t         ctrl,
    input  logic [reku_pkg::DEB_WIDTH-1:0] limit,
    output logic                        pending
);
    import reku_pkg::*;

    logic [DEB_WIDTH-1:0] count_reg, count_next;
    logic                 pending_reg, pending_next;

    always_comb begin
        count_next   = count_reg;
        pending_next = pending_reg;
        if (ctrl.sample) begin
            if (ctrl.pressed) begin
                if (count_reg < limit) begin
                    count_next = count_reg + DEB_WIDTH'(1);
                    if (count_next == limit) begin
                        pending_next = 1'b1;
                    end
                end
            end else begin
                count_next = '0;
            end
        end else if (ctrl.clear) begin
            pending_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            pending_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            pending_reg <= pending_next;
        end
    end

    assign pending = pending_reg;

endmodule

>>> hdl/reku_checker.sv
// Port-level checks for rotary_encoder_key_event_unit_top, with its bind.
// Depends on reku_pkg.
module reku_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input reku_pkg::req_t                      s_data,
    input logic                                m_valid,
    input logic                                m_ready,
    input reku_pkg::rsp_t                      m_data,
    input logic                                psel,
    input logic                                penable,
    input logic                                pwrite,
    input logic [reku_pkg::CFG_ADDR_WIDTH-1:0] paddr,
    input logic [reku_pkg::CFG_DATA_WIDTH-1:0] pwdata,
    input logic [reku_pkg::CFG_DATA_WIDTH-1:0] prdata,
    input logic                                pready
);
    import reku_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.event_code == EV_NONE || m_data.event_code == EV_CW
            || m_data.event_code == EV_CCW || m_data.event_code == EV_BUTTON
            || m_data.event_code == EV_KEY)
        else $error("bad event code");

    a_fetch: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.mode == MODE_FETCH && !m_valid |=> m_valid)
        else $error("fetch gave no result");

    a_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.mode == MODE_SAMPLE && !m_valid |=> !m_valid)
        else $error("sample gave a result");

    a_cfg: assert property (@(posedge aclk) disable iff (!aresetn)
        psel && penable && pwrite && pready && paddr[2] == REG_DEBOUNCE
        |=> prdata[DEB_WIDTH-1:0] == $past(pwdata[DEB_WIDTH-1:0]))
        else $error("debounce register readback mismatch");

endmodule

bind rotary_encoder_key_event_unit_top reku_checker u_reku_checker (.*);

>>> tb/rotary_encoder_key_event_unit_top_tb.sv
// Self-checking testbench for rotary_encoder_key_event_unit_top.
// Drives sample/fetch requests and APB writes, predicts every fetch result.
// Depends on reku_pkg and the DUT sources.
module rotary_encoder_key_event_unit_top_tb;
    import reku_pkg::*;

    localparam int MAX_CYCLES   = 200000;
    localparam int DRAIN_CYCLES = 4;
    localparam int PHASE_ITEMS  = 210;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    req_t                      s_data = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    rsp_t                      m_data;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [CFG_ADDR_WIDTH-1:0] paddr = '0;
    logic [CFG_DATA_WIDTH-1:0] pwdata = '0;
    logic [CFG_DATA_WIDTH-1:0] prdata;
    logic                      pready;

    // Predicted block state
    logic [DEB_WIDTH-1:0] press_limit = DEBOUNCE_RESET;
    logic                 last_chan_a = 1'b1;
    logic [POS_WIDTH-1:0] pos_count = '0;
    logic [POS_WIDTH-1:0] pos_reported = '0;
    logic [DEB_WIDTH-1:0] key_run = '0;
    logic [DEB_WIDTH-1:0] button_run = '0;
    logic                 key_flag = 1'b0;
    logic                 button_flag = 1'b0;
    rsp_t                 pending_events[$];

    int mismatches = 0;
    int cycles = 0;
    int burst_left = 0;
    int stall_mode = 0;
    int stall_left = 0;

    rotary_encoder_key_event_unit_top DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > MAX_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch @%0t: %s", $realtime, msg);
    endtask

    task automatic debounce_step(input logic pressed, inout logic [DEB_WIDTH-1:0] run,
                                 inout logic flag);
        if (pressed) begin
            if (run < press_limit) begin
                run = run + DEB_WIDTH'(1);
                if (run == press_limit)
                    flag = 1'b1;
            end
        end else begin
            run = '0;
        end
    endtask

    task automatic predict_request(input req_t r);
        logic [POS_WIDTH-1:0] delta;
        rsp_t ev;
        if (r.mode == MODE_SAMPLE) begin
            if (last_chan_a && !r.chan_a)
                pos_count = r.chan_b ? pos_count - POS_WIDTH'(1) : pos_count + POS_WIDTH'(1);
            last_chan_a = r.chan_a;
            debounce_step(r.key_level, key_run, key_flag);
            debounce_step(!r.button_level, button_run, button_flag);
        end else begin
            delta = pos_count - pos_reported;
            ev.event_code = EV_NONE;
            if (delta != '0) begin
                ev.event_code = delta[POS_WIDTH-1] ? EV_CCW : EV_CW;
                pos_reported = pos_count;
            end else if (button_flag) begin
                button_flag = 1'b0;
                ev.event_code = EV_BUTTON;
            end else if (key_flag) begin
                key_flag = 1'b0;
                ev.event_code = EV_KEY;
            end
            ev.position = pos_count;
            pending_events.push_back(ev);
        end
    endtask

    // Called right after a rising edge; returns right after the accepting edge.
    task automatic send_request(input req_t r);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_request(r);
    endtask

    task automatic send_sample(input logic a, input logic b, input logic key,
                               input logic button);
        req_t r;
        r = '{mode: MODE_SAMPLE, chan_a: a, chan_b: b, key_level: key,
              button_level: button};
        send_request(r);
    endtask

    task automatic send_fetch();
        req_t r;
        r = req_t'($urandom);
        r.mode = MODE_FETCH;
        send_request(r);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_events.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_debounce(input logic [DEB_WIDTH-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_DEBOUNCE, 2'b00};
        pwdata  <= CFG_DATA_WIDTH'(val);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        press_limit = val;
        // back-to-back readback
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata[DEB_WIDTH-1:0] !== val)
            report_mismatch($sformatf("press threshold readback %0d, wrote %0d",
                                      prdata[DEB_WIDTH-1:0], val));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Result checker
    always @(posedge aclk) begin
        rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_events.size() == 0) begin
                report_mismatch($sformatf("unexpected result code %0d pos %0d",
                                          m_data.event_code, m_data.position));
            end else begin
                want = pending_events.pop_front();
                if (m_data.event_code !== want.event_code || m_data.position !== want.position)
                    report_mismatch($sformatf("expected code %0d pos %0d, got code %0d pos %0d",
                                              want.event_code, want.position,
                                              m_data.event_code, m_data.position));
            end
        end
    end

    // Receiver stall pattern: runs of always-ready, random, sparse and periodic
    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 120);
        end
        stall_left--;
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            2: m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= (cycles % 5 == 0);
        endcase
    end

    task automatic test_rotation();
        send_fetch();                    // nothing pending after reset
        send_sample(1, 0, 0, 1);
        send_sample(0, 0, 0, 1);         // falling A, B low: up
        send_fetch();
        send_sample(1, 1, 0, 1);         // rising A: no move
        send_sample(0, 1, 0, 1);         // falling A, B high: down
        send_sample(1, 1, 0, 1);
        send_sample(0, 1, 0, 1);         // below zero
        send_fetch();
    endtask

    task automatic test_fetch_ignores_pins();
        req_t r;
        r = '{mode: MODE_FETCH, chan_a: 1'b1, chan_b: 1'b1, key_level: 1'b1,
              button_level: 1'b0};
        send_request(r);
        send_sample(0, 0, 0, 1);         // A still low: no edge
        send_fetch();
    endtask

    task automatic test_debounce_and_priority();
        repeat (5) send_sample(1, 0, 1, 1);   // key confirmed once, held
        send_sample(1, 0, 0, 1);              // key release
        send_sample(1, 0, 0, 0);
        send_sample(1, 0, 0, 1);              // button bounce
        repeat (3) send_sample(1, 0, 0, 0);   // button confirmed
        send_sample(0, 0, 1, 0);              // rotation on top
        repeat (4) send_fetch();              // rotation, button, key, none
    endtask

    task automatic run_pin_traffic(input int n);
        int  phase;
        int  dir;
        int  key_hold;
        int  button_hold;
        logic key_on;
        logic button_on;
        logic a;
        logic b;
        logic k;
        logic bt;
        req_t r;
        phase = 0;
        dir = 1;
        key_hold = 0;
        button_hold = 0;
        key_on = 1'b0;
        button_on = 1'b0;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 4) == 0) begin
                send_fetch();
            end else if ($urandom_range(0, 11) == 0) begin
                r = req_t'($urandom);
                r.mode = MODE_SAMPLE;
                send_request(r);
            end else begin
                if ($urandom_range(0, 7) == 0)
                    dir = -dir;
                if ($urandom_range(0, 1) == 0)
                    phase = (phase + dir + 4) % 4;
                case (phase)
                    0: begin a = 1'b1; b = 1'b1; end
                    1: begin a = 1'b0; b = 1'b1; end
                    2: begin a = 1'b0; b = 1'b0; end
                    default: begin a = 1'b1; b = 1'b0; end
                endcase
                if (key_hold == 0) begin
                    key_on = !key_on;
                    key_hold = $urandom_range(1, int'(press_limit) + 4);
                end
                key_hold--;
                if (button_hold == 0) begin
                    button_on = !button_on;
                    button_hold = $urandom_range(1, int'(press_limit) + 4);
                end
                button_hold--;
                k  = key_on ^ ($urandom_range(0, 19) == 0);
                bt = !(button_on ^ ($urandom_range(0, 19) == 0));
                send_sample(a, b, k, bt);
            end
        end
    endtask

    task automatic test_random_traffic();
        run_pin_traffic(PHASE_ITEMS);
    endtask

    task automatic test_debounce_settings();
        logic [DEB_WIDTH-1:0] settings[5];
        settings[0] = 4'd1;
        settings[1] = 4'd15;
        settings[2] = 4'd0;
        settings[3] = 4'd7;
        settings[4] = DEB_WIDTH'($urandom_range(1, 15));
        foreach (settings[i]) begin
            wait_idle();
            write_debounce(settings[i]);
            @(posedge aclk);
            run_pin_traffic(PHASE_ITEMS);
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_rotation();
        test_fetch_ignores_pins();
        test_debounce_and_priority();
        test_random_traffic();
        test_debounce_settings();
        wait_idle();
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
